// File: rtl/core/jfd_pkg.sv
// ----------------------------------------------------------------------------
// Joystick frame deframer package
// Shared constants, codes and types for the joystick frame deframer.
// ----------------------------------------------------------------------------
package jfd_pkg;

  // Default body length of a wireless frame, in bytes after the start byte.
  localparam int unsigned BT_LEN_DEF = 7;

  // Number of body bytes that are kept: four axes and the gait byte.
  localparam int unsigned STORE_DEPTH = 5;
  localparam int unsigned STORE_IDX_W = $clog2(STORE_DEPTH);
  localparam int unsigned AXIS_NUM    = 4;
  localparam int unsigned AXIS_IDX_W  = $clog2(AXIS_NUM);

  // Link modes.
  localparam logic LINK_RADIO = 1'b0;
  localparam logic LINK_HOST  = 1'b1;

  // Frame markers.
  localparam logic [7:0] RADIO_START = 8'h00;
  localparam logic [7:0] HOST_START  = 8'hAB;
  localparam logic [7:0] HOST_END    = 8'hCD;

  // Frame status codes.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_END = 1'b1;

  // Gait codes.
  localparam logic [1:0] GAIT_NONE   = 2'd0;
  localparam logic [1:0] GAIT_TRIPOD = 2'd1;
  localparam logic [1:0] GAIT_WAVE   = 2'd3;

  // Axis rescaling constants.
  localparam logic [7:0]  AXIS_OFFSET = 8'd20;
  localparam logic [7:0]  AXIS_FULL   = 8'd255;
  localparam logic [7:0]  AXIS_CLAMP  = 8'd230;
  // Reciprocal of five in 18 fractional bits, exact for the quotients used.
  localparam logic [15:0] RECIP_DIV5  = 16'd52429;

  // One result beat.
  typedef struct packed {
    logic [7:0] axis1_x;
    logic [7:0] axis1_y;
    logic [7:0] axis2_x;
    logic [7:0] axis2_y;
    logic [1:0] gait_pick;
    logic       frame_status;
  } jfd_result_t;

  // Handshake control from the parser to the top level.
  typedef struct packed {
    logic consume;
    logic emit;
  } jfd_ctrl_t;

endpackage

// File: rtl/core/jfd_rescale.sv
// ----------------------------------------------------------------------------
// Joystick axis rescaler
// Maps a raw axis byte through (d - 20) * 255 / 160, truncated towards zero,
// optionally inverted as 255 - q, and clamps the result to 0..230.
// ----------------------------------------------------------------------------
module jfd_rescale (
  input  logic [7:0] raw_i,
  input  logic       invert_i,
  output logic [7:0] axis_o
);

  import jfd_pkg::*;

  logic        below;
  logic [7:0]  offs;
  logic [15:0] scaled;
  logic [10:0] div32;
  logic [26:0] prod;
  logic [8:0]  quot;
  logic [8:0]  inv;

  // Offset and multiply by 255 as a shift and subtract.
  assign below  = (raw_i < AXIS_OFFSET);
  assign offs   = raw_i - AXIS_OFFSET;
  assign scaled = {offs, 8'h00} - {8'h00, offs};

  // Divide by 160 as a shift by five followed by a reciprocal of five.
  assign div32 = scaled[15:5];
  assign prod  = {16'h0000, div32} * {11'h000, RECIP_DIV5};
  assign quot  = prod[26:18];
  assign inv   = {1'b0, AXIS_FULL} - quot;

  // Clamp; a negative quotient means the byte sat below the offset.
  always_comb begin
    if (!invert_i) begin
      if (below) begin
        axis_o = 8'h00;
      end else if (quot > {1'b0, AXIS_CLAMP}) begin
        axis_o = AXIS_CLAMP;
      end else begin
        axis_o = quot[7:0];
      end
    end else begin
      if (below) begin
        axis_o = AXIS_CLAMP;
      end else if (quot > {1'b0, AXIS_FULL}) begin
        axis_o = 8'h00;
      end else if (inv > {1'b0, AXIS_CLAMP}) begin
        axis_o = AXIS_CLAMP;
      end else begin
        axis_o = inv[7:0];
      end
    end
  end

endmodule

// File: rtl/core/jfd_parser.sv
// ----------------------------------------------------------------------------
// Joystick frame parser
// Tracks the frame position, stores body bytes and forms a result beat when
// a frame completes. One byte is processed per cycle, except that a frame-ending byte waits for out_free_i.
// ----------------------------------------------------------------------------
module jfd_parser #(
  parameter int unsigned BtLen = jfd_pkg::BT_LEN_DEF,
  parameter int unsigned CntW  = $clog2(BtLen + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                link_mode_i,
  input  logic                byte_valid_i,
  input  logic [7:0]          byte_i,
  input  logic                out_free_i,
  output jfd_pkg::jfd_ctrl_t  ctrl_o,
  output jfd_pkg::jfd_result_t result_o
);

  import jfd_pkg::*;

  logic                  in_frame_q, in_frame_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [7:0]            raw_q    [STORE_DEPTH];
  logic [7:0]            mapped_q [AXIS_NUM];

  logic                  start_hit;
  logic                  store_en;
  logic                  map_en;
  logic                  emit;
  logic                  consume;
  logic [CntW-1:0]       count_inc;
  logic [7:0]            gait_byte;
  logic [7:0]            mapped_new;
  logic                  host_good;
  logic [STORE_IDX_W-1:0] store_idx;
  logic [AXIS_IDX_W-1:0]  axis_idx;

  assign store_idx = count_q[STORE_IDX_W-1:0];
  assign axis_idx  = count_q[AXIS_IDX_W-1:0];
  assign count_inc = count_q + CntW'(1);

  assign start_hit = (link_mode_i == LINK_HOST) ? (byte_i == HOST_START)
                                                : (byte_i == RADIO_START);

  // Frame position decode: which byte is stored, and whether the frame ends.
  always_comb begin
    store_en = 1'b0;
    emit     = 1'b0;
    count_d  = count_q;
    in_frame_d = in_frame_q;
    if (!in_frame_q) begin
      if (start_hit) begin
        in_frame_d = 1'b1;
        count_d    = '0;
      end
    end else if (link_mode_i == LINK_RADIO) begin
      if (count_q < CntW'(BtLen)) begin
        store_en = (count_q < CntW'(STORE_DEPTH));
        count_d  = count_inc;
      end
      if (count_d >= CntW'(BtLen)) begin
        emit       = 1'b1;
        in_frame_d = 1'b0;
        count_d    = '0;
      end
    end else begin
      if (count_q < CntW'(AXIS_NUM)) begin
        store_en = 1'b1;
        count_d  = count_inc;
      end else begin
        emit       = 1'b1;
        in_frame_d = 1'b0;
        count_d    = '0;
      end
    end
  end

  assign map_en  = store_en && (count_q < CntW'(AXIS_NUM));
  assign consume = byte_valid_i && (!emit || out_free_i);

  assign ctrl_o.consume = consume;
  assign ctrl_o.emit    = emit;

  // One rescaler, applied as each axis byte arrives.
  jfd_rescale u_rescale (
    .raw_i    (byte_i),
    .invert_i (axis_idx != '0),
    .axis_o   (mapped_new)
  );

  // Frame position state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      count_q    <= '0;
    end else if (consume) begin
      in_frame_q <= in_frame_d;
      count_q    <= count_d;
    end
  end

  // Body byte stores, raw and rescaled.
  always_ff @(posedge clk_i) begin
    if (consume && store_en) begin
      raw_q[store_idx] <= byte_i;
    end
    if (consume && map_en) begin
      mapped_q[axis_idx] <= mapped_new;
    end
  end

  // Gait byte may arrive in the very beat that ends the frame.
  assign gait_byte = (store_en && (count_q == CntW'(AXIS_NUM))) ? byte_i
                                                                : raw_q[AXIS_NUM];
  assign host_good = (byte_i == HOST_END);

  // Result beat formation.
  always_comb begin
    if (link_mode_i == LINK_RADIO) begin
      result_o.axis1_x      = mapped_q[0];
      result_o.axis1_y      = mapped_q[1];
      result_o.axis2_x      = mapped_q[2];
      result_o.axis2_y      = mapped_q[3];
      result_o.frame_status = STATUS_OK;
      if ((gait_byte >= {6'd0, GAIT_TRIPOD}) && (gait_byte <= {6'd0, GAIT_WAVE})) begin
        result_o.gait_pick = gait_byte[1:0];
      end else begin
        result_o.gait_pick = GAIT_NONE;
      end
    end else begin
      result_o.gait_pick = GAIT_NONE;
      if (host_good) begin
        result_o.axis1_x      = raw_q[0];
        result_o.axis1_y      = raw_q[1];
        result_o.axis2_x      = raw_q[2];
        result_o.axis2_y      = raw_q[3];
        result_o.frame_status = STATUS_OK;
      end else begin
        result_o.axis1_x      = 8'h00;
        result_o.axis1_y      = 8'h00;
        result_o.axis2_x      = 8'h00;
        result_o.axis2_y      = 8'h00;
        result_o.frame_status = STATUS_BAD_END;
      end
    end
  end

endmodule

// File: rtl/core/joystick_frame_deframer.sv
// ----------------------------------------------------------------------------
// Joystick frame deframer
// Deframes joystick packets from a received byte stream in wireless or host
// link mode and delivers one result beat per completed frame.
//
//   Channel   Direction  Handshake              Payload
//   in        receive    in_valid_i/in_stall_o  rx_byte_i
//   out       send       out_valid_o/out_stall_i axis*, gait_pick_o, frame_status_o
//   cfg       receive    cfg_wr_en_i            cfg_wr_data_i (link mode)
//
// One byte is taken every cycle while in_stall_o is low; the byte that completes
// a frame passes the input register, and its result is held in the result register.
// Reset is asynchronous and clears the frame position, link mode and valids;
// the byte stores are not cleared and are always written before they are read.
// While the result register is stalled, bytes that end no frame keep flowing.
// ----------------------------------------------------------------------------
module joystick_frame_deframer #(
  parameter int unsigned BtLen = jfd_pkg::BT_LEN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_wr_en_i,
  input  logic       cfg_wr_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] axis1_x_o,
  output logic [7:0] axis1_y_o,
  output logic [7:0] axis2_x_o,
  output logic [7:0] axis2_y_o,
  output logic [1:0] gait_pick_o,
  output logic       frame_status_o
);

  import jfd_pkg::*;

  logic        link_mode_q;
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        out_valid_q, out_valid_d;
  logic        out_free;
  logic        in_accept;
  jfd_ctrl_t   ctrl;
  jfd_result_t result;
  jfd_result_t result_q;

  // Link mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_mode_q <= LINK_RADIO;
    end else if (cfg_wr_en_i) begin
      link_mode_q <= cfg_wr_data_i;
    end
  end

  // Input register: frees whenever the parser takes its byte.
  assign in_stall_o = in_valid_q && !ctrl.consume;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (ctrl.consume) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Frame parser.
  jfd_parser #(
    .BtLen (BtLen)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .link_mode_i  (link_mode_q),
    .byte_valid_i (in_valid_q),
    .byte_i       (in_byte_q),
    .out_free_i   (out_free),
    .ctrl_o       (ctrl),
    .result_o     (result)
  );

  // Result register.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.consume && ctrl.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.consume && ctrl.emit) begin
      result_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign axis1_x_o      = result_q.axis1_x;
  assign axis1_y_o      = result_q.axis1_y;
  assign axis2_x_o      = result_q.axis2_x;
  assign axis2_y_o      = result_q.axis2_y;
  assign gait_pick_o    = result_q.gait_pick;
  assign frame_status_o = result_q.frame_status;

endmodule

// File: rtl/core/jfd_checker.sv
// ----------------------------------------------------------------------------
// Joystick frame deframer checker
// Port-level assertions for the joystick frame deframer, bound to the top.
// ----------------------------------------------------------------------------
module jfd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_wr_en_i,
  input logic       cfg_wr_data_i,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] rx_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] axis1_x_o,
  input logic [7:0] axis1_y_o,
  input logic [7:0] axis2_x_o,
  input logic [7:0] axis2_y_o,
  input logic [1:0] gait_pick_o,
  input logic       frame_status_o
);

  import jfd_pkg::*;

  // A stalled result beat stays and holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(axis1_x_o) &&
      $stable(axis1_y_o) && $stable(axis2_x_o) && $stable(axis2_y_o) &&
      $stable(gait_pick_o) && $stable(frame_status_o))
    else $error("result beat changed while stalled");

  // A bad end byte carries zeroed axes and no gait.
  a_bad_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_status_o == STATUS_BAD_END) |->
      (axis1_x_o == 8'h00) && (axis1_y_o == 8'h00) && (axis2_x_o == 8'h00) &&
      (axis2_y_o == 8'h00) && (gait_pick_o == GAIT_NONE))
    else $error("bad end beat carries data");

  // A gait choice only comes with a good frame.
  a_gait_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (gait_pick_o != GAIT_NONE) |-> frame_status_o == STATUS_OK)
    else $error("gait chosen on a bad frame");

  // No result beat straight out of reset.
  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result beat right after reset");

endmodule

bind joystick_frame_deframer jfd_checker u_jfd_checker (.*);
